// File: hdl/lfu_pkg.sv
// Shared types and constants for the LFU key-value store.
package lfu_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int USE_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [USE_W-1:0] USE_FIRST  = 32'd1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } lfu_state_t;

  // What the entry walk has found so far
  typedef struct packed {
    logic found;
    logic have_victim;
    logic have_free;
  } scan_flags_t;

endpackage

// File: hdl/lfu_scan.sv
// Entry walk: key match, least-used victim search and first free slot.
module lfu_scan #(
  parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF,
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     beat_vld,
  input  logic [IDX_W-1:0]         beat_idx,
  input  logic                     beat_live,
  input  logic [lfu_pkg::KEY_W-1:0] beat_key,
  input  logic [lfu_pkg::USE_W-1:0] beat_use,
  input  logic [lfu_pkg::KEY_W-1:0] req_key,
  output lfu_pkg::scan_flags_t     flags,
  output logic [IDX_W-1:0]         match_idx,
  output logic [lfu_pkg::USE_W-1:0] match_use,
  output logic [IDX_W-1:0]         victim_idx,
  output logic [IDX_W-1:0]         free_idx
);

  lfu_pkg::scan_flags_t flags_r, flags_nxt;
  logic [IDX_W-1:0]          match_idx_r, victim_idx_r, free_idx_r;
  logic [lfu_pkg::USE_W-1:0] match_use_r, vic_use_r;
  logic [lfu_pkg::KEY_W-1:0] vic_key_r;
  logic                      is_match, is_lower, is_first_free;

  always_comb begin
    is_match      = beat_vld && beat_live && !flags_r.found && (beat_key == req_key);
    // lower count wins; equal counts go to the smaller signed key
    is_lower      = beat_vld && beat_live &&
                    (!flags_r.have_victim || (beat_use < vic_use_r) ||
                     ((beat_use == vic_use_r) && ($signed(beat_key) < $signed(vic_key_r))));
    is_first_free = beat_vld && !beat_live && !flags_r.have_free;
    flags_nxt             = flags_r;
    flags_nxt.found       = flags_r.found || is_match;
    flags_nxt.have_victim = flags_r.have_victim || is_lower;
    flags_nxt.have_free   = flags_r.have_free || is_first_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_match) begin
      match_idx_r <= beat_idx;
      match_use_r <= beat_use;
    end
    if (is_lower) begin
      victim_idx_r <= beat_idx;
      vic_use_r    <= beat_use;
      vic_key_r    <= beat_key;
    end
    if (is_first_free) begin
      free_idx_r <= beat_idx;
    end
  end

  assign flags      = flags_r;
  assign match_idx  = match_idx_r;
  assign match_use  = match_use_r;
  assign victim_idx = victim_idx_r;
  assign free_idx   = free_idx_r;

endmodule

// File: hdl/lfu_cache_key_value_store.sv
// LFU key-value store top level: sequencer, entry memories and result port.
//
//   channel | direction | handshake         | beat carries
//   in_     | input     | in_valid/in_stall | action, lookup_key, write_value
//   out_    | output    | out_valid/out_stall | hit, read_value, evicted
//   cfg_    | input     | cfg_valid/cfg_ready | cache_capacity
//
// Each item runs through the sequencer states in order: the compare unit
// walks one entry a cycle through the key and use-count memories, the decide
// state decides and writes back, the out state shows the result until it is
// taken, and the sequencer then returns to idle.
// Reset is synchronous and clears the valid bits, the live count and the
// sequencer; the entry memories need no clearing. A stalled result holds
// the block, and input stays stalled until the result beat has gone.
module lfu_cache_key_value_store #(
  parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic signed [lfu_pkg::KEY_W-1:0] in_lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0] in_write_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0] out_read_value,
  output logic                         out_evicted,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_cache_capacity
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SCNT_W = IDX_W + 1;
  localparam int LIVE_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (LIVE_W > lfu_pkg::CAP_W) ? LIVE_W : lfu_pkg::CAP_W;

  lfu_pkg::lfu_state_t state_r, state_nxt;

  logic [lfu_pkg::CAP_W-1:0] cap_r;
  logic [MAX_ENTRIES-1:0]    valid_r;
  logic [LIVE_W-1:0]         live_r;
  logic [SCNT_W-1:0]         scan_cnt_r;
  logic                      beat_vld_r;
  logic [IDX_W-1:0]          beat_idx_r;

  logic                      action_r;
  logic [lfu_pkg::KEY_W-1:0] req_key_r;
  logic [lfu_pkg::VAL_W-1:0] req_value_r;
  logic                      hit_r, evict_r;

  logic [lfu_pkg::KEY_W-1:0] key_mem_r [MAX_ENTRIES];
  logic [lfu_pkg::VAL_W-1:0] val_mem_r [MAX_ENTRIES];
  logic [lfu_pkg::USE_W-1:0] use_mem_r [MAX_ENTRIES];
  logic [lfu_pkg::KEY_W-1:0] key_rd_r;
  logic [lfu_pkg::USE_W-1:0] use_rd_r;
  logic [lfu_pkg::VAL_W-1:0] val_rd_r;

  lfu_pkg::scan_flags_t      flags;
  logic [IDX_W-1:0]          match_idx, victim_idx, free_idx;
  logic [lfu_pkg::USE_W-1:0] match_use;

  logic                      in_accept, out_accept;
  logic                      scan_last, scan_rd, deciding;
  logic [IDX_W-1:0]          scan_addr;

  logic                      cap_zero, full, is_put;
  logic [CMP_W-1:0]          cap_ext, max_ext, eff_cap;
  logic                      ins, need_evict, do_ins, upd;
  logic [IDX_W-1:0]          slot;
  logic                      use_we, key_we, val_we;
  logic [IDX_W-1:0]          wr_addr;
  logic [lfu_pkg::USE_W-1:0] use_wd, use_up;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign cfg_ready  = 1'b1;
  assign scan_last  = (scan_cnt_r == SCNT_W'(MAX_ENTRIES));
  assign scan_addr  = scan_cnt_r[IDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_pkg::ST_IDLE:   if (in_accept) state_nxt = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN:   if (scan_last) state_nxt = lfu_pkg::ST_DECIDE;
      lfu_pkg::ST_DECIDE: state_nxt = lfu_pkg::ST_OUT;
      lfu_pkg::ST_OUT:    if (out_accept) state_nxt = lfu_pkg::ST_IDLE;
      default:            state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    scan_rd   = 1'b0;
    deciding  = 1'b0;
    unique case (state_r)
      lfu_pkg::ST_IDLE:   in_stall  = 1'b0;
      lfu_pkg::ST_SCAN:   scan_rd   = !scan_last;
      lfu_pkg::ST_DECIDE: deciding  = 1'b1;
      lfu_pkg::ST_OUT:    out_valid = 1'b1;
      default:            in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lfu_pkg::ST_IDLE;
      cap_r      <= lfu_pkg::CAP_RESET;
      scan_cnt_r <= '0;
      beat_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      beat_vld_r <= scan_rd;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_cache_capacity;
      end
      if (in_accept) begin
        scan_cnt_r <= '0;
      end else if (scan_rd) begin
        scan_cnt_r <= scan_cnt_r + SCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    beat_idx_r <= scan_addr;
    if (in_accept) begin
      action_r    <= in_action;
      req_key_r   <= in_lookup_key;
      req_value_r <= in_write_value;
    end
  end

  lfu_scan #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_accept),
    .beat_vld   (beat_vld_r),
    .beat_idx   (beat_idx_r),
    .beat_live  (valid_r[beat_idx_r]),
    .beat_key   (key_rd_r),
    .beat_use   (use_rd_r),
    .req_key    (req_key_r),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_use  (match_use),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // write-back decision, applied in the decide cycle
  always_comb begin
    is_put     = (action_r == lfu_pkg::ACT_PUT);
    cap_zero   = (cap_r == '0);
    cap_ext    = CMP_W'(cap_r);
    max_ext    = CMP_W'(MAX_ENTRIES);
    eff_cap    = (cap_ext > max_ext) ? max_ext : cap_ext;
    full       = (CMP_W'(live_r) >= eff_cap);
    ins        = is_put && !cap_zero && !flags.found;
    need_evict = ins && full && flags.have_victim;
    do_ins     = ins && (need_evict || flags.have_free);
    upd        = flags.found && (!is_put || !cap_zero);
    slot       = need_evict ? victim_idx : free_idx;
    use_up     = (match_use == '1) ? match_use : match_use + lfu_pkg::USE_FIRST;
    wr_addr    = upd ? match_idx : slot;
    use_wd     = upd ? use_up : lfu_pkg::USE_FIRST;
    use_we     = deciding && (upd || do_ins);
    key_we     = deciding && do_ins;
    val_we     = deciding && (do_ins || (upd && is_put));
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem_r[wr_addr] <= req_key_r;
    end
    if (scan_rd) begin
      key_rd_r <= key_mem_r[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem_r[wr_addr] <= use_wd;
    end
    if (scan_rd) begin
      use_rd_r <= use_mem_r[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem_r[wr_addr] <= req_value_r;
    end
    if (deciding) begin
      val_rd_r <= val_mem_r[match_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live_r  <= '0;
    end else if (deciding && do_ins) begin
      // the victim's slot is reused, so only a fresh slot grows the count
      valid_r[slot] <= 1'b1;
      if (!need_evict) begin
        live_r <= live_r + LIVE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (deciding) begin
      hit_r   <= flags.found;
      evict_r <= need_evict;
    end
  end

  assign out_hit        = hit_r;
  assign out_evicted    = evict_r;
  assign out_read_value = (action_r == lfu_pkg::ACT_PUT) ? req_value_r :
                          (hit_r ? val_rd_r : lfu_pkg::MISS_VALUE);

endmodule

// File: hdl/lfu_checker.sv
// Port-level checks for the LFU key-value store, bound to the top level.
module lfu_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_hit,
  input logic                         out_evicted
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("input taken or result shown straight after accept");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction reported for a present key");

endmodule

bind lfu_cache_key_value_store lfu_checker u_lfu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_hit     (out_hit),
  .out_evicted (out_evicted)
);
